FILE: sv/bak_pkg.sv
// Shared types, constants and helpers of the altitude Kalman filter.
package bak_pkg;

   localparam int FRAC_BITS = 16;
   localparam int NUM_W = 32 + FRAC_BITS;
   localparam int DCNT_W = $clog2(NUM_W + 1);
   localparam int MEM_DEPTH = 28;
   localparam int ADDR_W = 5;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef enum logic [1:0] {CMD_PREDICT, CMD_BARO, CMD_ACCEL, CMD_NONE} cmd_type;
   typedef enum logic [2:0] {
      REG_Q_POS, REG_Q_VEL, REG_Q_ACC, REG_R_BARO, REG_R_ACC, REG_P_INIT
   } reg_type;

   // Storage map: covariance row major, then estimates, gains, scaled gains.
   localparam addr_type X_BASE = 5'd16;
   localparam addr_type K_BASE = 5'd20;
   localparam addr_type T_BASE = 5'd24;

   localparam logic [31:0] P_INIT = 32'd131072;

   typedef struct packed {
      logic              is_div;
      logic              wr_en;
      addr_type          dst;
      logic              base_en;
      logic              base_neg;
      addr_type          base;
      logic [1:0]        nterms;
      addr_type          t1;
      logic              t1_neg;
      addr_type          t2;
      logic              t2_neg;
      logic signed [32:0] cval;
   } op_type;

   typedef struct packed {
      logic              done;
      logic signed [31:0] result;
   } eng_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh000000007FFFFFFF) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sh0000000080000000) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: sv/bak_div.sv
// Restoring divider, one quotient bit per cycle.
module bak_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [bak_pkg::NUM_W-1:0] num,
   input  logic [30:0]              den,
   output logic                     done,
   output logic [bak_pkg::NUM_W-1:0] quo
);
   import bak_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [DCNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [30:0]       rem_ff;
   logic [30:0]       den_ff;
   logic [31:0]       rem_sh;
   logic              qbit;
   logic [31:0]       diff;

   assign rem_sh = {rem_ff, num_ff[NUM_W-1]};
   assign qbit   = rem_sh >= {1'b0, den_ff};
   assign diff   = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_W-2:0], qbit};
         rem_ff <= qbit ? diff[30:0] : rem_sh[30:0];
      end
   end

   assign done = done_ff;
   assign quo  = num_ff;

endmodule

FILE: sv/bak_engine.sv
// State memory and the shared multiply-accumulate / divide unit.
module bak_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  bak_pkg::op_type           op,
   input  logic signed [31:0]        sc,
   output bak_pkg::eng_rsp_type      rsp
);
   import bak_pkg::*;

   typedef enum logic [2:0] {
      E_IDLE, E_BASE, E_MUL1, E_ACC1, E_ACC2, E_DIVW, E_WB
   } est_type;

   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

   est_type            st_ff;
   op_type             op_ff;
   logic               done_ff;
   logic signed [31:0] result_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] mul_ff;
   logic               pneg_ff;

   logic [31:0]          mem_ff [MEM_DEPTH];
   logic [MEM_DEPTH-1:0] vld_ff;
   logic [31:0]          mem_q_ff;
   logic [31:0]          init_q_ff;
   logic                 vld_q_ff;

   addr_type           rd_addr;
   logic signed [31:0] rdata;
   logic signed [63:0] rdata64;
   logic signed [63:0] prod;
   logic signed [63:0] term;
   logic signed [31:0] wb_val;
   logic               wr;
   logic [31:0]        pmag;
   logic [NUM_W-1:0]   dnum;
   logic               div_start;
   logic               div_done;
   logic [NUM_W-1:0]   div_quo;
   logic signed [63:0] q64;

   always_comb begin
      case (st_ff)
         E_IDLE:  rd_addr = op.base;
         E_BASE:  rd_addr = op_ff.t1;
         E_MUL1:  rd_addr = op_ff.t2;
         default: rd_addr = op_ff.base;
      endcase
   end

   // Entries never written read as their reset value.
   assign rdata   = vld_q_ff ? $signed(mem_q_ff) : $signed(init_q_ff);
   assign rdata64 = {{32{rdata[31]}}, rdata};
   assign prod    = rdata * sc;
   assign term    = (mul_ff + HALF) >>> FRAC_BITS;
   assign wb_val  = sat32(acc_ff);
   assign wr      = (st_ff == E_WB) && op_ff.wr_en;

   assign pmag      = rdata[31] ? 32'(-rdata) : 32'(rdata);
   assign dnum      = {pmag, {FRAC_BITS{1'b0}}} + NUM_W'(sc[30:1]);
   assign div_start = (st_ff == E_BASE) && op_ff.is_div;
   assign q64       = $signed({{(64 - NUM_W){1'b0}}, div_quo});

   bak_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (dnum),
      .den   (sc[30:0]),
      .done  (div_done),
      .quo   (div_quo)
   );

   always_ff @(posedge clock) begin
      if (wr) begin
         mem_ff[op_ff.dst] <= wb_val;
      end
      mem_q_ff  <= mem_ff[rd_addr];
      vld_q_ff  <= vld_ff[rd_addr];
      init_q_ff <= (rd_addr < 5'd16 && rd_addr[1:0] == rd_addr[3:2]) ? P_INIT : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr) begin
         vld_ff[op_ff.dst] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= E_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (st_ff)
            E_IDLE: begin
               if (start) begin
                  op_ff <= op;
                  st_ff <= E_BASE;
               end
            end
            E_BASE: begin
               if (op_ff.is_div) begin
                  pneg_ff <= rdata[31];
                  st_ff   <= E_DIVW;
               end else begin
                  acc_ff <= 64'(op_ff.cval)
                          + (op_ff.base_en ? (op_ff.base_neg ? -rdata64 : rdata64) : 64'sd0);
                  st_ff  <= (op_ff.nterms == 2'd0) ? E_WB : E_MUL1;
               end
            end
            E_MUL1: begin
               mul_ff <= prod;
               st_ff  <= E_ACC1;
            end
            E_ACC1: begin
               acc_ff <= op_ff.t1_neg ? acc_ff - term : acc_ff + term;
               mul_ff <= prod;
               st_ff  <= (op_ff.nterms == 2'd2) ? E_ACC2 : E_WB;
            end
            E_ACC2: begin
               acc_ff <= op_ff.t2_neg ? acc_ff - term : acc_ff + term;
               st_ff  <= E_WB;
            end
            E_DIVW: begin
               if (div_done) begin
                  acc_ff <= pneg_ff ? -q64 : q64;
                  st_ff  <= E_WB;
               end
            end
            E_WB: begin
               result_ff <= wb_val;
               done_ff   <= 1'b1;
               st_ff     <= E_IDLE;
            end
            default: st_ff <= E_IDLE;
         endcase
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.result = result_ff;

endmodule

FILE: sv/baro_accel_altitude_kalman.sv
// Top level: request handshake, registers and the operation sequencer.
//
// Four-state altitude Kalman filter (altitude, velocity, acceleration,
// accelerometer bias) in signed Q16.16. Each request yields one response
// with the four estimates. The estimates, covariance and gains live in one
// synchronous memory with a single read port; each operation reads its
// operands one at a time, then multiplies and accumulates or divides, and
// writes back where needed. A correction runs four gain divisions on a
// 48-step bit-serial divider. A correction whose S is not positive is
// skipped after S and only reads out the estimates, as does the unused
// command. The next request is taken in the cycle after the response is
// loaded, also while that response still waits on rsp_stall.
module baro_accel_altitude_kalman (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic signed [31:0] req_operand_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [31:0] rsp_altitude,
   output logic signed [31:0] rsp_velocity,
   output logic signed [31:0] rsp_acceleration,
   output logic signed [31:0] rsp_accel_bias,
   output logic        rsp_update_skipped,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [30:0] csr_wr_data
);
   import bak_pkg::*;

   typedef enum logic [1:0] {T_IDLE, T_ISSUE, T_WAIT, T_FIN} tst_type;
   typedef enum logic [2:0] {
      PH_PRED, PH_S, PH_V, PH_K, PH_T, PH_X, PH_P, PH_OUT
   } phase_type;

   tst_type            st_ff;
   phase_type          ph_ff;
   logic [4:0]         cnt_ff;
   logic [1:0]         row_ff;
   cmd_type            cmd_ff;
   logic signed [31:0] val_ff;
   logic signed [31:0] s_ff;
   logic signed [31:0] v_ff;
   logic signed [31:0] t_ff;
   logic               skip_ff;
   logic signed [31:0] xo_ff [4];
   logic [30:0]        qp_ff, qv_ff, qa_ff, rb_ff, ra_ff;
   logic               rsp_valid_ff;
   logic signed [31:0] alt_ff, vel_ff, acc_ff, bias_ff;
   logic               rskip_ff;

   op_type             op;
   logic signed [31:0] sc;
   eng_rsp_type        eng;
   logic               slot_free;
   logic               r;
   logic [1:0]         j2, r1, kk;
   addr_type           pii, xi, col;
   logic [30:0]        rsel;

   assign req_stall = (st_ff != T_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign r    = cnt_ff[0];
   assign j2   = cnt_ff[2:1];
   assign r1   = {1'b0, r} + 2'd1;
   assign kk   = cnt_ff[1:0] - 2'd1;
   assign pii  = (cmd_ff == CMD_BARO) ? 5'd0 : 5'd10;
   assign xi   = (cmd_ff == CMD_BARO) ? X_BASE : X_BASE + 5'd2;
   assign col  = (cmd_ff == CMD_BARO) ? 5'd0 : 5'd2;
   assign rsel = (cmd_ff == CMD_BARO) ? rb_ff : ra_ff;

   always_comb begin
      op = '0;
      sc = 32'sd0;
      case (ph_ff)
         PH_PRED: begin
            sc       = val_ff;
            op.wr_en = 1'b1;
            op.base_en = 1'b1;
            op.t2_neg = 1'b1;
            op.nterms = r ? 2'd2 : 2'd1;
            if (cnt_ff < 5'd16) begin
               if (!cnt_ff[3]) begin
                  // A P: rows 0 and 1, column by column
                  op.base = {2'b00, r, j2};
                  op.t1   = {1'b0, r1, j2};
                  op.t2   = {1'b0, 2'd3, j2};
               end else begin
                  // (A P) A^T: columns 0 and 1, row by row
                  op.base = {1'b0, j2, 1'b0, r};
                  op.t1   = {1'b0, j2, r1};
                  op.t2   = {1'b0, j2, 2'd3};
               end
            end else if (cnt_ff < 5'd18) begin
               op.base = X_BASE + {4'd0, r};
               op.t1   = X_BASE + {3'd0, r1};
               op.t2   = X_BASE + 5'd3;
            end else begin
               op.nterms = 2'd0;
               case (cnt_ff)
                  5'd18:   begin op.base = 5'd0;  op.cval = {2'b00, qp_ff}; end
                  5'd19:   begin op.base = 5'd5;  op.cval = {2'b00, qv_ff}; end
                  default: begin op.base = 5'd10; op.cval = {2'b00, qa_ff}; end
               endcase
            end
            op.dst = op.base;
         end
         PH_S: begin
            op.base_en = 1'b1;
            op.base    = pii;
            op.cval    = {2'b00, rsel};
         end
         PH_V: begin
            op.base_en  = 1'b1;
            op.base_neg = 1'b1;
            op.base     = xi;
            op.cval     = {val_ff[31], val_ff};
         end
         PH_K: begin
            sc        = s_ff;
            op.is_div = 1'b1;
            op.wr_en  = 1'b1;
            op.base   = {1'b0, cnt_ff[1:0], 2'b00} + col;
            op.dst    = K_BASE + {3'd0, cnt_ff[1:0]};
         end
         PH_T: begin
            sc        = s_ff;
            op.wr_en  = 1'b1;
            op.nterms = 2'd1;
            op.t1     = K_BASE + {3'd0, cnt_ff[1:0]};
            op.dst    = T_BASE + {3'd0, cnt_ff[1:0]};
         end
         PH_X: begin
            sc         = v_ff;
            op.wr_en   = 1'b1;
            op.base_en = 1'b1;
            op.nterms  = 2'd1;
            op.base    = X_BASE + {3'd0, cnt_ff[1:0]};
            op.t1      = K_BASE + {3'd0, cnt_ff[1:0]};
            op.dst     = op.base;
         end
         PH_P: begin
            sc         = t_ff;
            op.base_en = 1'b1;
            if (cnt_ff == 5'd0) begin
               op.base = T_BASE + {3'd0, row_ff};
            end else begin
               op.wr_en  = 1'b1;
               op.nterms = 2'd1;
               op.t1_neg = 1'b1;
               op.base   = {1'b0, row_ff, kk};
               op.t1     = K_BASE + {3'd0, kk};
               op.dst    = op.base;
            end
         end
         default: begin
            op.base_en = 1'b1;
            op.base    = X_BASE + {3'd0, cnt_ff[1:0]};
         end
      endcase
   end

   bak_engine u_engine (
      .clock (clock),
      .reset (reset),
      .start (st_ff == T_ISSUE),
      .op    (op),
      .sc    (sc),
      .rsp   (eng)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         qp_ff <= 31'd66;
         qv_ff <= 31'd655;
         qa_ff <= 31'd6554;
         rb_ff <= 31'd23593;
         ra_ff <= 31'd66;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_Q_POS:  qp_ff <= csr_wr_data;
            REG_Q_VEL:  qv_ff <= csr_wr_data;
            REG_Q_ACC:  qa_ff <= csr_wr_data;
            REG_R_BARO: rb_ff <= csr_wr_data;
            REG_R_ACC:  ra_ff <= csr_wr_data;
            // ignored; covariance starts from the reset diagonal after reset
            REG_P_INIT: ;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (st_ff)
            T_IDLE: begin
               if (req_valid) begin
                  cmd_ff  <= cmd_type'(req_cmd);
                  val_ff  <= req_operand_value;
                  skip_ff <= 1'b0;
                  cnt_ff  <= '0;
                  row_ff  <= '0;
                  unique case (cmd_type'(req_cmd))
                     CMD_PREDICT:         ph_ff <= PH_PRED;
                     CMD_BARO, CMD_ACCEL: ph_ff <= PH_S;
                     default:             ph_ff <= PH_OUT;
                  endcase
                  st_ff <= T_ISSUE;
               end
            end
            T_ISSUE: st_ff <= T_WAIT;
            T_WAIT: begin
               if (eng.done) begin
                  st_ff <= T_ISSUE;
                  case (ph_ff)
                     PH_PRED: begin
                        cnt_ff <= cnt_ff + 5'd1;
                        if (cnt_ff == 5'd20) begin
                           ph_ff  <= PH_OUT;
                           cnt_ff <= '0;
                        end
                     end
                     PH_S: begin
                        s_ff <= eng.result;
                        if (eng.result <= 32'sd0) begin
                           skip_ff <= 1'b1;
                           ph_ff   <= PH_OUT;
                        end else begin
                           ph_ff <= PH_V;
                        end
                     end
                     PH_V: begin
                        v_ff  <= eng.result;
                        ph_ff <= PH_K;
                     end
                     PH_K, PH_T, PH_X: begin
                        cnt_ff <= cnt_ff + 5'd1;
                        if (cnt_ff == 5'd3) begin
                           cnt_ff <= '0;
                           ph_ff  <= (ph_ff == PH_K) ? PH_T
                                   : (ph_ff == PH_T) ? PH_X : PH_P;
                        end
                     end
                     PH_P: begin
                        if (cnt_ff == 5'd0) begin
                           t_ff <= eng.result;
                        end
                        cnt_ff <= cnt_ff + 5'd1;
                        if (cnt_ff == 5'd4) begin
                           cnt_ff <= '0;
                           row_ff <= row_ff + 2'd1;
                           if (row_ff == 2'd3) begin
                              ph_ff <= PH_OUT;
                           end
                        end
                     end
                     default: begin
                        xo_ff[cnt_ff[1:0]] <= eng.result;
                        cnt_ff <= cnt_ff + 5'd1;
                        if (cnt_ff == 5'd3) begin
                           st_ff <= T_FIN;
                        end
                     end
                  endcase
               end
            end
            T_FIN: begin
               if (slot_free) begin
                  alt_ff       <= xo_ff[0];
                  vel_ff       <= xo_ff[1];
                  acc_ff       <= xo_ff[2];
                  bias_ff      <= xo_ff[3];
                  rskip_ff     <= skip_ff;
                  rsp_valid_ff <= 1'b1;
                  st_ff        <= T_IDLE;
               end
            end
            default: st_ff <= T_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_altitude       = alt_ff;
   assign rsp_velocity       = vel_ff;
   assign rsp_acceleration   = acc_ff;
   assign rsp_accel_bias     = bias_ff;
   assign rsp_update_skipped = rskip_ff;

endmodule
